// File: rtl/dltq_pkg.sv
// Shared types and constants of the delta list timer queue.
`default_nettype none
package dltq_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int IDX_W       = $clog2(TIMER_COUNT);
    localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
    localparam int MS_W        = 24;
    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_CHECK = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [3:0]      timer_id;
        logic [MS_W-1:0] duration_ms;
    } req_t;

    typedef struct packed {
        logic            status;
        logic            fired;
        logic [3:0]      fired_id;
        logic            has_next;
        logic [MS_W-1:0] next_ms;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic scan_hit;
        logic fetch;
        logic remove;
        logic walk_init;
        logic walk_next;
        logic walk_hit;
        logic insert;
        logic exec;
        logic finish;
    } dltq_cmd_t;

    typedef struct packed {
        logic [1:0]       in_type;
        logic             in_id_ok;
        logic             count_zero;
        logic             is_start;
        logic             scan_end;
        logic             match;
        logic             walk_stop;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } dltq_sts_t;

endpackage
`default_nettype wire

// File: rtl/delta_list_timer_queue_top.sv
// Top level of the delta list timer queue.
// A request carries a type (tick, start, stop, check), a timer identity and
// a duration, and each request gives exactly one response on the rsp channel.
// Both channels use valid/ready; a request is taken only while the sequencer
// is idle, one at a time. Tick and check go through the exec state to the
// response register. Stop walks the sorted list one entry per cycle. Start
// first does the same stop pass, then walks the list again to find its place.
// The response register holds a finished response while the next request is
// taken; a response that finds the register still full waits in the
// sequencer until the receiver takes the old one.
// Reset empties the list and clears the elapsed time and the response valid.
// No clearing pass is needed: only entries below the fill count are read.
`default_nettype none
module delta_list_timer_queue_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire dltq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output dltq_pkg::rsp_t      rsp
);

    dltq_pkg::dltq_cmd_t cmd;
    dltq_pkg::dltq_sts_t sts;

    dltq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dltq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // The list never holds more entries than there are timers.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sts.count) <= dltq_pkg::TIMER_COUNT)
        else $error("queue fill count exceeds timer count");

    // A stop on an empty list never fires a timer.
    a_status_fire: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.status && rsp.fired))
        else $error("response reports both empty stop and fire");

    // With no timer left, the reported delay is zero.
    a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.has_next) |-> (rsp.next_ms == '0))
        else $error("next delay set with empty queue");

    // A stalled response stays valid and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed while stalled");

endmodule
`default_nettype wire

// File: rtl/dltq_ctrl.sv
// Sequencer of the delta list timer queue.
`default_nettype none
module dltq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire dltq_pkg::dltq_sts_t sts,
    output dltq_pkg::dltq_cmd_t     cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_FETCH  = 9'b000000100,
        ST_REMOVE = 9'b000001000,
        ST_WINIT  = 9'b000010000,
        ST_WALK   = 9'b000100000,
        ST_INSERT = 9'b001000000,
        ST_EXEC   = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (sts.in_type)
                        dltq_pkg::REQ_TICK,
                        dltq_pkg::REQ_CHECK: state_next = ST_EXEC;
                        dltq_pkg::REQ_STOP:
                            state_next = (sts.count_zero || !sts.in_id_ok) ? ST_FINISH : ST_SCAN;
                        default:
                            state_next = sts.in_id_ok ? ST_SCAN : ST_FINISH;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_end)
                    state_next = sts.is_start ? ST_WINIT : ST_FINISH;
                else if (sts.match)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = ST_FETCH;
                end
                else
                    cmd.scan_next = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_REMOVE;
            end
            ST_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = sts.is_start ? ST_WINIT : ST_FINISH;
            end
            ST_WINIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                if (sts.walk_stop)
                begin
                    cmd.walk_hit = 1'b1;
                    state_next   = ST_INSERT;
                end
                else
                    cmd.walk_next = 1'b1;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_FINISH;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: rtl/dltq_dp.sv
// Datapath of the delta list timer queue: list cells, walk registers, result register.
`default_nettype none
module dltq_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dltq_pkg::req_t      req,
    input  wire dltq_pkg::dltq_cmd_t cmd,
    output dltq_pkg::dltq_sts_t      sts,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output dltq_pkg::rsp_t           rsp
);

    localparam int N  = dltq_pkg::TIMER_COUNT;
    localparam int IW = dltq_pkg::IDX_W;
    localparam int CW = dltq_pkg::CNT_W;
    localparam int MW = dltq_pkg::MS_W;

    logic [3:0]    slot_timer_reg [N];
    logic [MW-1:0] slot_delta_reg [N];
    logic [CW-1:0] count_reg;
    logic [MW-1:0] acc_reg;
    dltq_pkg::req_t req_reg;
    logic [CW-1:0] idx_reg, pos_reg;
    logic [MW-1:0] d_reg, rem_reg, adj_reg, sum_reg;
    logic          status_reg, fired_reg;
    logic [3:0]    fired_id_reg;
    dltq_pkg::rsp_t rsp_reg;
    logic          rsp_valid_reg;

    logic [3:0]    rd_timer;
    logic [MW-1:0] rd_delta;
    logic [MW:0]   sum_wide;
    logic          fire;
    logic          is_check;
    logic          full;

    assign rd_timer = slot_timer_reg[idx_reg[IW-1:0]];
    assign rd_delta = slot_delta_reg[idx_reg[IW-1:0]];
    assign sum_wide = {1'b0, rd_delta} + {1'b0, d_reg};
    assign is_check = (req_reg.req_type == dltq_pkg::REQ_CHECK);
    assign fire     = (count_reg != '0) && (acc_reg != '0) && (slot_delta_reg[0] <= acc_reg);
    assign full     = (32'(count_reg) >= N);

    always_comb
    begin
        sts.in_type    = req.req_type;
        sts.in_id_ok   = (32'(req.timer_id) < N);
        sts.count_zero = (count_reg == '0);
        sts.is_start   = (req_reg.req_type == dltq_pkg::REQ_START);
        sts.scan_end   = (idx_reg >= count_reg);
        sts.match      = (rd_timer == req_reg.timer_id);
        sts.walk_stop  = (idx_reg >= count_reg) || (rd_delta > rem_reg);
        sts.out_free   = !rsp_valid_reg || rsp_ready;
        sts.count      = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.remove)
                count_reg <= count_reg - 1'b1;
            if (cmd.insert && !full)
                count_reg <= count_reg + 1'b1;
            if (cmd.exec && is_check && fire)
                count_reg <= count_reg - 1'b1;
            if (cmd.walk_init && count_reg == '0)
                acc_reg <= '0;
            if (cmd.exec)
            begin
                if (is_check)
                    acc_reg <= '0;
                else if (acc_reg != dltq_pkg::MS_MAX)
                    acc_reg <= acc_reg + 1'b1;
            end
            if (cmd.finish)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req;
            idx_reg      <= '0;
            status_reg   <= (req.req_type == dltq_pkg::REQ_STOP) && (count_reg == '0);
            fired_reg    <= 1'b0;
            fired_id_reg <= '0;
        end
        if (cmd.scan_next || cmd.walk_next)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.scan_hit)
        begin
            pos_reg <= idx_reg;
            d_reg   <= rd_delta;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.fetch)
            sum_reg <= sum_wide[MW] ? dltq_pkg::MS_MAX : sum_wide[MW-1:0];
        if (cmd.walk_init)
        begin
            idx_reg <= '0;
            rem_reg <= req_reg.duration_ms;
        end
        if (cmd.walk_next)
            rem_reg <= rem_reg - rd_delta;
        if (cmd.walk_hit)
        begin
            pos_reg <= idx_reg;
            adj_reg <= rd_delta - rem_reg;
        end
        if (cmd.exec && is_check && fire)
        begin
            fired_reg    <= 1'b1;
            fired_id_reg <= slot_timer_reg[0];
        end
        if (cmd.finish)
        begin
            rsp_reg.status   <= status_reg;
            rsp_reg.fired    <= fired_reg;
            rsp_reg.fired_id <= fired_id_reg;
            rsp_reg.has_next <= (count_reg != '0);
            rsp_reg.next_ms  <= (count_reg != '0) ? slot_delta_reg[0] : '0;
        end
    end

    // List cells: shift from a neighbor, load a walk or request value, or age cell 0.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < N - 1; j++)
        begin
            if (cmd.remove && CW'(j) >= pos_reg)
            begin
                slot_timer_reg[j] <= slot_timer_reg[j+1];
                slot_delta_reg[j] <= (CW'(j) == pos_reg) ? sum_reg : slot_delta_reg[j+1];
            end
            if (cmd.exec && is_check && fire)
            begin
                slot_timer_reg[j] <= slot_timer_reg[j+1];
                slot_delta_reg[j] <= slot_delta_reg[j+1];
            end
        end
        if (cmd.exec && is_check && !fire && count_reg != '0 && acc_reg != '0)
            slot_delta_reg[0] <= slot_delta_reg[0] - acc_reg;
        for (int j = 1; j < N; j++)
        begin
            if (cmd.insert && !full && CW'(j) > pos_reg)
            begin
                slot_timer_reg[j] <= slot_timer_reg[j-1];
                slot_delta_reg[j] <= (CW'(j - 1) == pos_reg) ? adj_reg : slot_delta_reg[j-1];
            end
        end
        for (int j = 0; j < N; j++)
        begin
            if (cmd.insert && CW'(j) == pos_reg)
            begin
                if (!full)
                begin
                    slot_timer_reg[j] <= req_reg.timer_id;
                    slot_delta_reg[j] <= rem_reg;
                end
                else if (pos_reg < count_reg)
                    slot_delta_reg[j] <= adj_reg;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
